// ===== rtl/core/ssxc_pkg.sv =====
package ssxc_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [31:0] crc_type;
   typedef logic [3:0]  key_pos_type;
   typedef logic [3:0]  tail_cnt_type;
   typedef logic [2:0]  trl_idx_type;

   localparam int unsigned KEY_LEN     = 13;
   localparam int unsigned TRAILER_LEN = 8;
   localparam int unsigned SUM_LEN     = 4;
   localparam int unsigned TAIL_LEN    = TRAILER_LEN + SUM_LEN;

   localparam crc_type      CRC_POLY  = 32'hEDB8_8320;
   localparam crc_type      CRC_INIT  = 32'hFFFF_FFFF;
   localparam key_pos_type  KEY_LAST  = key_pos_type'(KEY_LEN - 1);
   localparam tail_cnt_type TAIL_FULL = tail_cnt_type'(TAIL_LEN);

   // key "STarYZgr3DL11"; out-of-range positions read as position 0
   function automatic byte_type key_byte(key_pos_type pos);
      byte_type b;
      case (pos)
         4'd1:    b = 8'h54;
         4'd2:    b = 8'h61;
         4'd3:    b = 8'h72;
         4'd4:    b = 8'h59;
         4'd5:    b = 8'h5A;
         4'd6:    b = 8'h67;
         4'd7:    b = 8'h72;
         4'd8:    b = 8'h33;
         4'd9:    b = 8'h44;
         4'd10:   b = 8'h4C;
         4'd11:   b = 8'h31;
         4'd12:   b = 8'h31;
         default: b = 8'h53;
      endcase
      return b;
   endfunction

   function automatic key_pos_type key_pos_next(key_pos_type pos);
      key_pos_type n;
      if (pos >= KEY_LAST) begin
         n = '0;
      end else begin
         n = pos + 4'd1;
      end
      return n;
   endfunction

   function automatic byte_type trailer_byte(trl_idx_type idx);
      byte_type b;
      case (idx)
         3'd0:    b = 8'd40;
         3'd1:    b = 8'd94;
         3'd2:    b = 8'd1;
         3'd3:    b = 8'd10;
         3'd6:    b = 8'd9;
         default: b = 8'd0;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/core/ssxc_req_if.sv =====
interface ssxc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source(output valid, output data_byte, output final_byte, input ready);
   modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== rtl/core/ssxc_rsp_if.sv =====
interface ssxc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;

   modport source(output valid, output out_byte, output frame_end, input ready);
   modport sink(input valid, input out_byte, input frame_end, output ready);
endinterface

// ===== rtl/core/ssxc_crc_byte.sv =====
// Reflected CRC-32 update over one byte, eight bit steps unrolled.
module ssxc_crc_byte
   import ssxc_pkg::*;
(
   input  crc_type  crc_in,
   input  byte_type data_in,
   output crc_type  crc_out
);

   always_comb begin
      crc_type c;
      c = crc_in ^ {24'd0, data_in};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

// ===== rtl/core/save_stream_xor_crc_encoder_unit.sv =====
// An accepted byte shows up on rsp in the next cycle (result register).
// Throughput: one byte per cycle while the output side keeps up and no trailer is being sent.
// A byte with final_byte set adds a 12-byte trailer (8 constant bytes, then
// the 4 CRC bytes LSB first); req ready stays low until the last of them is
// loaded into the result register, and longer while rsp is held off.
// Reset (synchronous, active high): CRC to all ones, key position 0, no trailer
// pending, output register empty.
module save_stream_xor_crc_encoder_unit
   import ssxc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   ssxc_req_if.sink        req_chan,
   ssxc_rsp_if.source      rsp_chan
);

   // running state
   crc_type      crc_ff, crc_in;
   key_pos_type  key_pos_ff, key_pos_in;
   // trailer bytes still to send, counts TAIL_LEN down to 0
   tail_cnt_type tail_cnt_ff, tail_cnt_in;
   // finished checksum held for the trailer
   crc_type      sum_ff, sum_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   byte_type     out_byte_ff, out_byte_in;
   logic         frame_end_ff, frame_end_in;

   crc_type      crc_upd;
   tail_cnt_type tail_idx;
   logic         out_free;
   logic         req_xfer;
   logic         tail_busy;

   ssxc_crc_byte u_crc (
      .crc_in  (crc_ff),
      .data_in (req_chan.data_byte),
      .crc_out (crc_upd)
   );

   // result slot can take a new byte when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign tail_busy = (tail_cnt_ff != '0);
   assign req_chan.ready = out_free && !tail_busy;
   assign req_xfer  = req_chan.valid && req_chan.ready;

   // position in the 12-byte tail: 0..7 constant trailer, 8..11 checksum
   assign tail_idx = TAIL_FULL - tail_cnt_ff;

   always_comb begin
      crc_in       = crc_ff;
      key_pos_in   = key_pos_ff;
      tail_cnt_in  = tail_cnt_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_byte_in  = out_byte_ff;
      frame_end_in = frame_end_ff;

      if (out_free && tail_busy) begin
         rsp_valid_in = 1'b1;
         tail_cnt_in  = tail_cnt_ff - 4'd1;
         frame_end_in = (tail_cnt_ff == 4'd1);
         if (tail_idx[3]) begin
            out_byte_in = sum_ff[8 * tail_idx[1:0] +: 8];
         end else begin
            out_byte_in = trailer_byte(tail_idx[2:0]);
         end
      end else if (req_xfer) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = req_chan.data_byte ^ key_byte(key_pos_ff);
         frame_end_in = 1'b0;
         if (req_chan.final_byte) begin
            // file done: latch the inverted CRC and start over
            sum_in      = ~crc_upd;
            tail_cnt_in = TAIL_FULL;
            crc_in      = CRC_INIT;
            key_pos_in  = '0;
         end else begin
            crc_in      = crc_upd;
            key_pos_in  = key_pos_next(key_pos_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         key_pos_ff   <= '0;
         tail_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         key_pos_ff   <= key_pos_in;
         tail_cnt_ff  <= tail_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      out_byte_ff  <= out_byte_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.frame_end = frame_end_ff;

   // final byte arms the full trailer and rewinds CRC and key
   a_final_arms_tail: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_chan.final_byte) |=>
         (tail_cnt_ff == TAIL_FULL && crc_ff == CRC_INIT && key_pos_ff == '0))
      else $error("final byte did not arm trailer / rewind state");

   // key position never leaves 0..12
   a_key_pos_range: assert property (@(posedge clock) disable iff (reset)
      key_pos_ff <= KEY_LAST)
      else $error("key position out of range");

   // trailer never runs past its length
   a_tail_range: assert property (@(posedge clock) disable iff (reset)
      tail_cnt_ff <= TAIL_FULL)
      else $error("trailer count out of range");

   // last tail byte carries frame_end and shows as valid
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (out_free && tail_cnt_ff == 4'd1) |=> (rsp_valid_ff && frame_end_ff))
      else $error("frame_end missing on last checksum byte");

   // plain data bytes never carry frame_end
   a_no_early_end: assert property (@(posedge clock) disable iff (reset)
      (req_xfer) |=> !frame_end_ff)
      else $error("frame_end on a data byte");

endmodule

// ===== tb/save_stream_xor_crc_encoder_unit_tb.sv =====
module save_stream_xor_crc_encoder_unit_tb;
   import ssxc_pkg::*;

   // ---------------------------------------------------------------------
   // Local types and constants
   // ---------------------------------------------------------------------

   // one plaintext byte as offered on the request side
   typedef struct packed {
      byte_type data;
      logic     fin;
   } plain_item_type;

   // one byte as it must leave on the response side
   typedef struct packed {
      byte_type val;
      logic     last;
   } enc_byte_type;

   // receiver stall patterns, picked anew at random at regular intervals
   typedef enum int unsigned {
      RX_OPEN,     // always ready
      RX_COIN,     // ready on a coin flip
      RX_QUARTER,  // ready one cycle in four
      RX_MOSTLY    // ready seven times in eight
   } rx_mode_type;

   // key text, first character in the top byte
   localparam logic [8*KEY_LEN-1:0]     KEY_TEXT   = "STarYZgr3DL11";
   // constant trailer, first byte in the top byte
   localparam logic [8*TRAILER_LEN-1:0] TRAIL_BITS = {8'd40, 8'd94, 8'd1, 8'd10,
                                                      8'd0, 8'd0, 8'd9, 8'd0};

   localparam int IDLE_LIMIT   = 1000;  // cycles without any transfer
   localparam int ITEM_TARGET  = 410;
   localparam int MID_PAUSE_AT = 200;   // item count at which the sender drains
   localparam int LONG_HOLD    = 100;   // receiver hold-off, in cycles
   localparam int HOLD_AT_A    = 150;   // response counts that start a hold-off
   localparam int HOLD_AT_B    = 500;

   // ---------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always #5 clock = ~clock;

   ssxc_req_if req_chan();
   ssxc_rsp_if rsp_chan();

   save_stream_xor_crc_encoder_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // ---------------------------------------------------------------------
   // Scoreboard state
   // ---------------------------------------------------------------------
   plain_item_type plain_q[$];   // bytes not yet transferred; head is on the bus
   enc_byte_type   cipher_q[$];  // expected response bytes, oldest first

   crc_type run_crc = CRC_INIT;  // predicted running CRC of the current file
   int      key_idx = 0;         // predicted key position
   int      mismatch_cnt = 0;

   // reflected CRC-32, one byte, bitwise
   function automatic crc_type crc32_step(crc_type crc, byte_type b);
      crc_type c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Work out what one transferred plaintext byte must produce: the
   // ciphertext byte, and on a final byte the trailer plus the CRC.
   task automatic encode_plain_byte(input plain_item_type it);
      enc_byte_type r;
      crc_type      sum;
      run_crc = crc32_step(run_crc, it.data);
      r.val   = it.data ^ KEY_TEXT[8*(KEY_LEN-1-key_idx) +: 8];
      r.last  = 1'b0;
      cipher_q.push_back(r);
      key_idx = (key_idx == KEY_LEN - 1) ? 0 : key_idx + 1;
      if (it.fin) begin
         for (int k = 0; k < TRAILER_LEN; k++) begin
            r.val  = TRAIL_BITS[8*(TRAILER_LEN-1-k) +: 8];
            r.last = 1'b0;
            cipher_q.push_back(r);
         end
         // inverted CRC goes out LSB first; last byte closes the frame
         sum = ~run_crc;
         for (int k = 0; k < SUM_LEN; k++) begin
            r.val  = sum[8*k +: 8];
            r.last = (k == SUM_LEN - 1);
            cipher_q.push_back(r);
         end
         // next file starts from scratch
         run_crc = CRC_INIT;
         key_idx = 0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps in between.
   // Payload only changes when the bus is free (no valid, or a transfer).
   // ---------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.data_byte  <= '0;
         req_chan.final_byte <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            encode_plain_byte(plain_q[0]);
            void'(plain_q.pop_front());
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (plain_q.size() > 0) begin
               req_chan.valid      <= 1'b1;
               req_chan.data_byte  <= plain_q[0].data;
               req_chan.final_byte <= plain_q[0].fin;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  // about a third of the bursts run straight into the next one
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response receiver: stall pattern is picked anew at regular intervals; at two
   // points it holds off for a long stretch so the block backs up and
   // drops req ready while the sender keeps offering.
   // ---------------------------------------------------------------------
   rx_mode_type rx_mode   = RX_OPEN;
   int          rx_cyc    = 0;
   int          rx_cnt    = 0;
   int          hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rx_cnt++;
            if (rx_cnt == HOLD_AT_A || rx_cnt == HOLD_AT_B) begin
               hold_left = LONG_HOLD;
            end
         end
         rx_cyc++;
         if (rx_cyc % 64 == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN: begin
                  rsp_chan.ready <= 1'b1;
               end
               RX_COIN: begin
                  rsp_chan.ready <= 1'($urandom_range(0, 1));
               end
               RX_QUARTER: begin
                  rsp_chan.ready <= (rx_cyc % 4 == 0);
               end
               default: begin
                  rsp_chan.ready <= ($urandom_range(0, 7) != 0);
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: every transfer is checked against the oldest
   // expected byte, field by field.
   // ---------------------------------------------------------------------
   enc_byte_type want;

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (cipher_q.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual out_byte %02h frame_end %0b",
                     $time, rsp_chan.out_byte, rsp_chan.frame_end);
            mismatch_cnt++;
         end else begin
            want = cipher_q.pop_front();
            if (rsp_chan.out_byte !== want.val) begin
               $display("%0t: out_byte mismatch, expected %02h actual %02h",
                        $time, want.val, rsp_chan.out_byte);
               mismatch_cnt++;
            end
            if (rsp_chan.frame_end !== want.last) begin
               $display("%0t: frame_end mismatch, expected %0b actual %0b",
                        $time, want.last, rsp_chan.frame_end);
               mismatch_cnt++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: too long without a transfer on either side ends the run.
   // ---------------------------------------------------------------------
   int idle_cyc = 0;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cyc <= 0;
      end else begin
         idle_cyc <= idle_cyc + 1;
      end
      if (idle_cyc >= IDLE_LIMIT) begin
         $display("save_stream_xor_crc_encoder_unit test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic add_byte(input byte_type data, input logic fin);
      plain_item_type it;
      it.data = data;
      it.fin  = fin;
      plain_q.push_back(it);
   endtask

   // sender pause: nothing new until every byte is out and checked
   task automatic drain();
      while (plain_q.size() != 0 || cipher_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      int       n_items;
      int       len;
      int       pick;
      bit       flat;
      bit       paused;
      byte_type fill;

      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = '0;
      req_chan.final_byte = 1'b0;
      rsp_chan.ready      = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: one-byte files at both data extremes
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      // 14 bytes: key position wraps past its last entry inside one file
      for (int i = 0; i < 14; i++) begin
         case (i)
            0:       add_byte(8'h00, 1'b0);
            1:       add_byte(8'hFF, 1'b0);
            default: add_byte((i % 2) ? 8'hA5 : 8'h5A, i == 13);
         endcase
      end
      // zero bytes must still enter the CRC
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b1);
      // single-bit patterns at both ends of the byte
      add_byte(8'h80, 1'b0);
      add_byte(8'h01, 1'b1);
      n_items = 21;
      drain();

      // random files: mostly short, some long, a few single-byte
      paused = 1'b0;
      while (n_items < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            len = 1;
         end else if (pick < 8) begin
            len = $urandom_range(1, 20);
         end else begin
            len = $urandom_range(21, 60);
         end
         // last file is cut to land on the item target
         if (len > ITEM_TARGET - n_items) begin
            len = ITEM_TARGET - n_items;
         end
         flat = ($urandom_range(0, 7) == 0);
         fill = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
         for (int i = 0; i < len; i++) begin
            add_byte(flat ? fill : byte_type'($urandom_range(0, 255)), i == len - 1);
         end
         n_items += len;
         if (!paused && n_items >= MID_PAUSE_AT) begin
            paused = 1'b1;
            drain();
         end
      end

      drain();
      // let any late, unexpected output show up before the verdict
      repeat (20) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("save_stream_xor_crc_encoder_unit test passed");
      end else begin
         $display("save_stream_xor_crc_encoder_unit test failed");
      end
      $finish;
   end

endmodule
